### hdl/smph_pkg.sv
package smph_pkg;

	localparam int LVL_W = 19;
	localparam int FRAC_W = 17;

	localparam int S0_MDBM = -127000;
	localparam int S9_MDBM = -73000;
	localparam int TOP_MDBM = -13000;
	localparam int MDB_PER_S_UNIT = 6000;
	localparam int PEAK_RESET_MS = 10000;

	localparam int PEAK_STEP_TICKS = 50;
	localparam int PEAK_STEP_MDB = 500;
	localparam int LEVEL_MIN = -150000;
	localparam int LEVEL_MAX = 20000;
	localparam int ELAPSED_MAX = 131071;
	localparam int Q16_ONE = 65536;
	localparam int HOLD_TIME_MIN = 100;
	localparam int HOLD_TIME_MAX = 2000;
	localparam int SNAP_MAX = 4096;

	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_HOLD_RST = 2'd2;

	localparam logic [1:0] DECAY_FAST = 2'd0;
	localparam logic [1:0] DECAY_MED = 2'd1;
	localparam logic [1:0] DECAY_SLOW = 2'd2;

	typedef enum logic [2:0] {
		REG_PEAK_MODE = 3'd0,
		REG_HOLD_EN = 3'd1,
		REG_HOLD_TIME = 3'd2,
		REG_DECAY_SEL = 3'd3,
		REG_ATTACK = 3'd4,
		REG_RELEASE = 3'd5,
		REG_SNAP = 3'd6
	} cfg_reg_t;

	// level to Q16 scale: floor((A*x + B) / D) done as (x*M + B') >> FRAC_SHIFT
	localparam int FRAC_SHIFT = 37;
	localparam int SPAN_LO = S9_MDBM - S0_MDBM;
	localparam int SPAN_HI = TOP_MDBM - S9_MDBM;
	localparam longint FRAC_M_LO =
		((longint'(6 * Q16_ONE) << FRAC_SHIFT) + longint'(10 * SPAN_LO) - 1)
		/ longint'(10 * SPAN_LO);
	localparam longint FRAC_M_HI =
		((longint'(4 * Q16_ONE) << FRAC_SHIFT) + longint'(10 * SPAN_HI) - 1)
		/ longint'(10 * SPAN_HI);
	localparam longint FRAC_B_LO = longint'(1) << (FRAC_SHIFT - 1);
	localparam longint FRAC_B_HI = ((longint'(6 * Q16_ONE + 5) << FRAC_SHIFT) + 9) / 10;
	localparam int M_LO_W = 19;
	localparam int M_HI_W = 18;
	localparam int SUM_W = 56;

	// S-unit / dB-over readout: floor(n / d) as (n*M) >> RD_SHIFT
	localparam int RD_SHIFT = 29;
	localparam int RD_M_W = 20;
	localparam int RD_N_W = 17;
	localparam int RD_Q_W = 8;
	localparam longint RD_M_OVER = ((longint'(1) << RD_SHIFT) + 999) / 1000;
	localparam longint RD_M_SU =
		((longint'(1) << RD_SHIFT) + MDB_PER_S_UNIT - 1) / MDB_PER_S_UNIT;
	localparam int OVER_MAX = 170;
	localparam int SU_MAX = 9;

	typedef struct packed {
		logic hi;
		logic [FRAC_W+M_LO_W-1:0] p_lo;
		logic [FRAC_W+M_HI_W-1:0] p_hi;
	} frac_part_t;

	function automatic frac_part_t frac_mul(input logic signed [LVL_W-1:0] dbm);
		logic signed [LVL_W-1:0] c;
		logic [FRAC_W-1:0] x;
		logic [M_LO_W+M_HI_W-1:0] m;
		frac_part_t r;
		c = dbm;
		if (c < S0_MDBM) c = LVL_W'(S0_MDBM);
		if (c > TOP_MDBM) c = LVL_W'(TOP_MDBM);
		r.hi = (c > S9_MDBM);
		x = r.hi ? FRAC_W'(c - S9_MDBM) : FRAC_W'(c - S0_MDBM);
		m = r.hi ? (M_LO_W+M_HI_W)'(FRAC_M_HI) : (M_LO_W+M_HI_W)'(FRAC_M_LO);
		r.p_lo = (FRAC_W+M_LO_W)'(x) * (FRAC_W+M_LO_W)'(m[M_LO_W-1:0]);
		r.p_hi = (FRAC_W+M_HI_W)'(x) * (FRAC_W+M_HI_W)'(m[M_LO_W+M_HI_W-1:M_LO_W]);
		return r;
	endfunction

	function automatic logic [FRAC_W-1:0] frac_sum(input frac_part_t p);
		logic [SUM_W-1:0] s;
		logic [SUM_W-FRAC_SHIFT-1:0] v;
		s = SUM_W'({p.p_hi, {M_LO_W{1'b0}}}) + SUM_W'(p.p_lo)
			+ (p.hi ? SUM_W'(FRAC_B_HI) : SUM_W'(FRAC_B_LO));
		v = s[SUM_W-1:FRAC_SHIFT];
		if (v > (SUM_W-FRAC_SHIFT)'(Q16_ONE)) return FRAC_W'(Q16_ONE);
		return FRAC_W'(v);
	endfunction

endpackage

### hdl/signal_meter_peak_hold_ballistics_top.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: cmd; tdata: level_mdbm
// m_*       out  m_tvalid/m_tready  tdata: needle, target, peak, hold, hold line, S, over S9
// apb       in   psel/penable       7 registers at byte address 4*i, pready tied high
//
// One item per cycle unless m_tready stalls; each result is registered at every stage.
// Stages: state update, scale multiplies, scale sums/readout, needle step (its own loop).
// Reset clears meter state to the S0 level and config to its defaults; no clearing pass.
// Stalls on m_tready fill bubbles first; s_tready drops only when all four stages are full.
module signal_meter_peak_hold_ballistics_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [23:0]  s_tdata,   // [18:0] level_mdbm
	input  logic [1:0]   s_tuser,   // [1:0] cmd
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata    // needle_frac, target_frac, peak_mdbm, hold_mdbm,
	                                // hold_line_frac, s_units, over_s9_db
);
	import smph_pkg::*;

	// config
	logic        peak_mode_q;
	logic        hold_en_q;
	logic [10:0] hold_time_q;
	logic [1:0]  decay_sel_q;
	logic [15:0] attack_q;
	logic [15:0] release_q;
	logic [12:0] snap_q;

	// meter state
	logic signed [LVL_W-1:0] level_q, peak_q, hold_q, start_q;
	logic [5:0]  step_q;
	logic        decay_q;
	logic [13:0] rcnt_q;
	logic [16:0] elapsed_q;
	logic        run_q;
	logic [FRAC_W-1:0] needle_q;

	logic signed [LVL_W-1:0] level_n, peak_n, hold_n, start_n;
	logic [5:0]  step_n;
	logic        decay_n;
	logic [13:0] rcnt_n;
	logic [16:0] elapsed_n;
	logic        run_n;

	logic signed [LVL_W-1:0] raw_in, lv_in;
	logic [16:0] over_t;
	logic [4:0]  rate;
	logic [21:0] dec;
	logic signed [23:0] hv;

	logic accept, cfg_wr;
	logic en2, en3, en4;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	// stage 1
	logic [1:0] cmd_s1;
	logic signed [LVL_W-1:0] disp_s1, hold_s1, level_s1, peak_s1;
	frac_part_t fd_c, fh_c;
	logic above9_c, above0_c, vis_c, low_c;
	logic [RD_N_W-1:0] rd_n;
	logic [RD_M_W-1:0] rd_m;
	logic [RD_N_W+RD_M_W-1:0] rd_p;

	// stage 2
	logic [1:0] cmd_s2;
	logic signed [LVL_W-1:0] peak_s2, hold_s2;
	frac_part_t fd_s2, fh_s2;
	logic above9_s2, above0_s2, vis_s2, low_s2;
	logic [RD_Q_W-1:0] rdq_s2;
	logic [3:0] su_c;
	logic [7:0] over_c;

	// stage 3
	logic [1:0] cmd_s3;
	logic signed [LVL_W-1:0] peak_s3, hold_s3;
	logic [FRAC_W-1:0] target_s3, hmap_s3;
	logic [3:0] su_s3;
	logic [7:0] over_s3;
	logic vis_s3, low_s3;
	logic signed [FRAC_W:0] nd;
	logic [FRAC_W-1:0] mag, st, needle_n, hfrac_c;
	logic [15:0] alpha;
	logic [32:0] prod;

	// output
	logic [FRAC_W-1:0] needle_s4, target_s4, hfrac_s4;
	logic signed [LVL_W-1:0] peak_s4, hold_s4;
	logic [3:0] su_s4;
	logic [7:0] over_s4;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign accept = s_tvalid & s_tready;

	assign en4 = !vld_s4 || m_tready;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign s_tready = !vld_s1 || en2;
	assign m_tvalid = vld_s4;

	always_comb begin
		unique case (paddr[4:2])
			REG_PEAK_MODE: prdata = 32'(peak_mode_q);
			REG_HOLD_EN:   prdata = 32'(hold_en_q);
			REG_HOLD_TIME: prdata = 32'(hold_time_q);
			REG_DECAY_SEL: prdata = 32'(decay_sel_q);
			REG_ATTACK:    prdata = 32'(attack_q);
			REG_RELEASE:   prdata = 32'(release_q);
			REG_SNAP:      prdata = 32'(snap_q);
			default:       prdata = 32'd0;
		endcase
	end

	// stage 0: item against meter state
	always_comb begin
		raw_in = $signed(s_tdata[LVL_W-1:0]);
		if (raw_in < LEVEL_MIN) lv_in = LVL_W'(LEVEL_MIN);
		else if (raw_in > LEVEL_MAX) lv_in = LVL_W'(LEVEL_MAX);
		else lv_in = raw_in;

		level_n = level_q;
		peak_n = peak_q;
		step_n = step_q;
		decay_n = decay_q;
		rcnt_n = rcnt_q;
		hold_n = hold_q;
		start_n = start_q;
		elapsed_n = elapsed_q;
		run_n = run_q;

		unique case (s_tuser)
			CMD_SAMPLE: begin
				level_n = lv_in;
				if (lv_in > peak_q) begin
					peak_n = lv_in;
					decay_n = 1'b1;
					step_n = 6'd0;
				end
				if (hold_en_q && lv_in > hold_q) begin
					hold_n = lv_in;
					start_n = lv_in;
					elapsed_n = 17'd0;
					run_n = 1'b1;
				end
			end
			CMD_TICK: begin
				if (decay_q) begin
					if (step_q >= 6'(PEAK_STEP_TICKS - 1)) begin
						step_n = 6'd0;
						peak_n = peak_q - LVL_W'(PEAK_STEP_MDB);
						if (peak_n < level_q) begin
							peak_n = level_q;
							decay_n = 1'b0;
						end
					end else begin
						step_n = step_q + 6'd1;
					end
				end
				if (rcnt_q >= 14'(PEAK_RESET_MS - 1)) begin
					rcnt_n = 14'd0;
					peak_n = level_q;
				end else begin
					rcnt_n = rcnt_q + 14'd1;
				end
				if (run_q && elapsed_q != 17'(ELAPSED_MAX)) elapsed_n = elapsed_q + 17'd1;
			end
			CMD_HOLD_RST: begin
				hold_n = level_q;
				start_n = level_q;
				run_n = 1'b0;
				elapsed_n = 17'd0;
			end
			default: ;
		endcase

		// hold line linear decay after hold time
		unique case (decay_sel_q)
			DECAY_FAST: rate = 5'd20;
			DECAY_SLOW: rate = 5'd5;
			default:    rate = 5'd10;
		endcase
		over_t = elapsed_n - 17'(hold_time_q);
		dec = 22'(over_t) * 22'(rate);
		hv = 24'(start_n) - $signed({2'b00, dec});
		if (hold_en_q && run_n && elapsed_n > 17'(hold_time_q))
			hold_n = (hv <= level_n) ? level_n : LVL_W'(hv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_mode_q <= 1'b0;
			hold_en_q <= 1'b0;
			hold_time_q <= 11'd1000;
			decay_sel_q <= DECAY_MED;
			attack_q <= 16'd16384;
			release_q <= 16'd4096;
			snap_q <= 13'd66;
			level_q <= LVL_W'(S0_MDBM);
			peak_q <= LVL_W'(S0_MDBM);
			hold_q <= LVL_W'(S0_MDBM);
			start_q <= LVL_W'(S0_MDBM);
			step_q <= 6'd0;
			decay_q <= 1'b0;
			rcnt_q <= 14'd0;
			elapsed_q <= 17'd0;
			run_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_PEAK_MODE: peak_mode_q <= pwdata[0];
				REG_HOLD_EN: begin
					hold_en_q <= pwdata[0];
					hold_q <= level_q;
					start_q <= level_q;
					run_q <= 1'b0;
					elapsed_q <= 17'd0;
				end
				REG_HOLD_TIME: begin
					if (pwdata[10:0] < 11'(HOLD_TIME_MIN)) hold_time_q <= 11'(HOLD_TIME_MIN);
					else if (pwdata[10:0] > 11'(HOLD_TIME_MAX)) hold_time_q <= 11'(HOLD_TIME_MAX);
					else hold_time_q <= pwdata[10:0];
				end
				REG_DECAY_SEL: decay_sel_q <= pwdata[1:0];
				REG_ATTACK:    attack_q <= pwdata[15:0];
				REG_RELEASE:   release_q <= pwdata[15:0];
				REG_SNAP:      snap_q <= (pwdata[12:0] > 13'(SNAP_MAX)) ? 13'(SNAP_MAX)
					: pwdata[12:0];
				default: ;
			endcase
		end else if (accept) begin
			level_q <= level_n;
			peak_q <= peak_n;
			hold_q <= hold_n;
			start_q <= start_n;
			step_q <= step_n;
			decay_q <= decay_n;
			rcnt_q <= rcnt_n;
			elapsed_q <= elapsed_n;
			run_q <= run_n;
		end
	end

	// stage 1: scale multiplies, readout divide, hold visibility
	always_comb begin
		fd_c = frac_mul(disp_s1);
		fh_c = frac_mul(hold_s1);
		above9_c = (disp_s1 > S9_MDBM);
		above0_c = (disp_s1 > S0_MDBM);
		rd_n = above9_c ? RD_N_W'(disp_s1 - S9_MDBM + 500)
			: RD_N_W'(disp_s1 - S0_MDBM + MDB_PER_S_UNIT / 2);
		rd_m = above9_c ? RD_M_W'(RD_M_OVER) : RD_M_W'(RD_M_SU);
		rd_p = (RD_N_W+RD_M_W)'(rd_n) * (RD_N_W+RD_M_W)'(rd_m);
		vis_c = hold_en_q && (hold_s1 > S0_MDBM + 1000);
		low_c = (hold_s1 <= level_s1 + 10);
	end

	// stage 2: scale sums, S-unit and dB-over clamp
	always_comb begin
		if (above9_s2) begin
			su_c = 4'(SU_MAX);
			over_c = (rdq_s2 > RD_Q_W'(OVER_MAX)) ? 8'(OVER_MAX) : 8'(rdq_s2);
		end else begin
			over_c = 8'd0;
			if (!above0_s2) su_c = 4'd0;
			else if (rdq_s2 > RD_Q_W'(SU_MAX)) su_c = 4'(SU_MAX);
			else su_c = 4'(rdq_s2);
		end
	end

	// stage 3: needle snap / step, hold line placement
	always_comb begin
		nd = $signed({1'b0, target_s3}) - $signed({1'b0, needle_q});
		mag = nd[FRAC_W] ? FRAC_W'(-nd) : FRAC_W'(nd);
		alpha = nd[FRAC_W] ? release_q : attack_q;
		prod = 33'(mag) * 33'(alpha);
		st = FRAC_W'((prod + 33'd32768) >> 16);
		if (mag <= FRAC_W'(snap_q)) needle_n = target_s3;
		else if (cmd_s3 == CMD_TICK) needle_n = nd[FRAC_W] ? needle_q - st : needle_q + st;
		else needle_n = needle_q;

		if (!vis_s3) hfrac_c = '0;
		else if (low_s3) hfrac_c = needle_n;
		else hfrac_c = (needle_n > hmap_s3) ? needle_n : hmap_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			needle_q <= '0;
		end else begin
			if (s_tready) vld_s1 <= s_tvalid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en4 && vld_s3) needle_q <= needle_n;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			cmd_s1 <= s_tuser;
			disp_s1 <= peak_mode_q ? peak_n : level_n;
			hold_s1 <= hold_n;
			level_s1 <= level_n;
			peak_s1 <= peak_n;
		end
		if (en2) begin
			cmd_s2 <= cmd_s1;
			peak_s2 <= peak_s1;
			hold_s2 <= hold_s1;
			fd_s2 <= fd_c;
			fh_s2 <= fh_c;
			above9_s2 <= above9_c;
			above0_s2 <= above0_c;
			rdq_s2 <= rd_p[RD_SHIFT +: RD_Q_W];
			vis_s2 <= vis_c;
			low_s2 <= low_c;
		end
		if (en3) begin
			cmd_s3 <= cmd_s2;
			peak_s3 <= peak_s2;
			hold_s3 <= hold_s2;
			target_s3 <= frac_sum(fd_s2);
			hmap_s3 <= frac_sum(fh_s2);
			su_s3 <= su_c;
			over_s3 <= over_c;
			vis_s3 <= vis_s2;
			low_s3 <= low_s2;
		end
		if (en4) begin
			needle_s4 <= needle_n;
			target_s4 <= target_s3;
			peak_s4 <= peak_s3;
			hold_s4 <= hold_s3;
			hfrac_s4 <= hfrac_c;
			su_s4 <= su_s3;
			over_s4 <= over_s3;
		end
	end

	assign m_tdata = {3'b000, over_s4, su_s4, hfrac_s4, hold_s4, peak_s4, target_s4, needle_s4};

endmodule

### tb/signal_meter_peak_hold_ballistics_top_tb.sv
module signal_meter_peak_hold_ballistics_top_tb;
	import smph_pkg::*;

	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 12;
	localparam int MAX_REPORTS = 100;
	localparam int RANDOM_ITEMS = 1200;
	localparam int RANDOM_PHASES = 8;
	localparam int LONG_TICKS = 200;

	// lowest bit up: needle, target, peak, hold, hold line, S-units, over S9
	typedef struct packed {
		logic [7:0] over_s9;
		logic [3:0] s_units;
		logic [FRAC_W-1:0] hold_line;
		logic signed [LVL_W-1:0] hold;
		logic signed [LVL_W-1:0] peak;
		logic [FRAC_W-1:0] target;
		logic [FRAC_W-1:0] needle;
	} reading_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid;
	logic s_tready;
	logic [23:0] s_tdata;   // [18:0] level_mdbm
	logic [1:0] s_tuser;    // [1:0] cmd
	logic m_tvalid;
	logic m_tready;
	logic [103:0] m_tdata;  // [16:0] needle, [33:17] target, [52:34] peak, [71:53] hold,
	                        // [88:72] hold line, [92:89] S-units, [100:93] over S9

	signal_meter_peak_hold_ballistics_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// meter model state
	logic cfg_peak_mode;
	logic cfg_hold_en;
	logic [1:0] cfg_decay;
	int cfg_hold_time;
	int cfg_attack;
	int cfg_release;
	int cfg_snap;
	int lvl;
	int pk;
	int pk_steps;
	logic pk_decaying;
	int peak_snap_count;
	int hold_val;
	int hold_start;
	int hold_ms;
	logic hold_active;
	int needle;

	reading_t readings_due[$];

	int errors;
	int n_results;
	int n_samples;
	int n_ticks;
	int n_hold_rst;
	int n_unused;
	int n_reg_writes;

	bit tx_gaps;
	int burst_left;
	bit rx_fast;
	int rx_hold_left;
	int rx_mode;
	int rx_mode_left;
	int rx_phase;

	function automatic void meter_reset();
		cfg_peak_mode = 1'b0;
		cfg_hold_en = 1'b0;
		cfg_hold_time = 1000;
		cfg_decay = DECAY_MED;
		cfg_attack = 16384;
		cfg_release = 4096;
		cfg_snap = 66;
		lvl = S0_MDBM;
		pk = S0_MDBM;
		hold_val = S0_MDBM;
		hold_start = S0_MDBM;
		pk_steps = 0;
		pk_decaying = 1'b0;
		peak_snap_count = 0;
		hold_ms = 0;
		hold_active = 1'b0;
		needle = 0;
	endfunction

	function automatic void meter_apply_config(cfg_reg_t idx, logic [31:0] val);
		int t;
		case (idx)
			REG_PEAK_MODE: cfg_peak_mode = val[0];
			REG_HOLD_EN: begin
				cfg_hold_en = val[0];
				hold_val = lvl;
				hold_start = lvl;
				hold_active = 1'b0;
				hold_ms = 0;
			end
			REG_HOLD_TIME: begin
				t = int'(val[10:0]);
				if (t < HOLD_TIME_MIN) t = HOLD_TIME_MIN;
				if (t > HOLD_TIME_MAX) t = HOLD_TIME_MAX;
				cfg_hold_time = t;
			end
			REG_DECAY_SEL: cfg_decay = val[1:0];
			REG_ATTACK: cfg_attack = int'(val[15:0]);
			REG_RELEASE: cfg_release = int'(val[15:0]);
			REG_SNAP: begin
				t = int'(val[12:0]);
				cfg_snap = t > SNAP_MAX ? SNAP_MAX : t;
			end
			default: ;
		endcase
	endfunction

	// S0..S9 -> 0..0.6, S9..TOP -> 0.6..1.0, rounded half up
	function automatic int scale_q16(int dbm);
		longint c;
		longint span;
		longint v;
		c = dbm;
		if (c < S0_MDBM) c = S0_MDBM;
		if (c > TOP_MDBM) c = TOP_MDBM;
		if (c <= S9_MDBM) begin
			span = longint'(S9_MDBM) - longint'(S0_MDBM);
			if (span <= 0) return 0;
			v = (longint'(6 * Q16_ONE) * (c - S0_MDBM) + 5 * span) / (10 * span);
		end else begin
			span = longint'(TOP_MDBM) - longint'(S9_MDBM);
			if (span <= 0) return Q16_ONE;
			v = (longint'(2 * Q16_ONE) * (3 * span + 2 * (c - S9_MDBM)) + 5 * span)
				/ (10 * span);
		end
		if (v < 0) v = 0;
		if (v > Q16_ONE) v = Q16_ONE;
		return int'(v);
	endfunction

	function automatic reading_t meter_predict(logic [1:0] cmd, logic [LVL_W-1:0] raw);
		int v;
		int rate;
		int tgt;
		int d;
		int mag;
		int st;
		int hl;
		int dv;
		int su;
		int over;
		longint hv;
		longint a;
		reading_t r;
		case (cmd)
			CMD_SAMPLE: begin
				v = $signed(raw);
				if (v < LEVEL_MIN) v = LEVEL_MIN;
				if (v > LEVEL_MAX) v = LEVEL_MAX;
				lvl = v;
				if (lvl > pk) begin
					pk = lvl;
					pk_decaying = 1'b1;
					pk_steps = 0;
				end
				if (cfg_hold_en && lvl > hold_val) begin
					hold_val = lvl;
					hold_start = lvl;
					hold_ms = 0;
					hold_active = 1'b1;
				end
			end
			CMD_TICK: begin
				if (pk_decaying) begin
					pk_steps++;
					if (pk_steps >= PEAK_STEP_TICKS) begin
						pk_steps = 0;
						pk -= PEAK_STEP_MDB;
						if (pk < lvl) begin
							pk = lvl;
							pk_decaying = 1'b0;
						end
					end
				end
				peak_snap_count++;
				if (peak_snap_count >= PEAK_RESET_MS) begin
					peak_snap_count = 0;
					pk = lvl;
				end
				if (hold_active && hold_ms < ELAPSED_MAX) hold_ms++;
			end
			CMD_HOLD_RST: begin
				hold_val = lvl;
				hold_start = lvl;
				hold_active = 1'b0;
				hold_ms = 0;
			end
			default: ;
		endcase

		if (cfg_hold_en && hold_active && hold_ms > cfg_hold_time) begin
			rate = cfg_decay == DECAY_FAST ? 20 : cfg_decay == DECAY_SLOW ? 5 : 10;
			hv = longint'(hold_start) - longint'(rate) * longint'(hold_ms - cfg_hold_time);
			hold_val = hv <= lvl ? lvl : int'(hv);
		end

		dv = cfg_peak_mode ? pk : lvl;
		tgt = scale_q16(dv);
		d = tgt - needle;
		mag = d < 0 ? -d : d;
		if (mag <= cfg_snap) needle = tgt;

		if (cmd == CMD_TICK) begin
			d = tgt - needle;
			mag = d < 0 ? -d : d;
			if (mag <= cfg_snap) begin
				needle = tgt;
			end else begin
				a = d >= 0 ? cfg_attack : cfg_release;
				st = int'((longint'(mag) * a + 32768) >>> 16);
				needle += d >= 0 ? st : -st;
			end
		end

		hl = 0;
		if (cfg_hold_en && hold_val > S0_MDBM + 1000) begin
			if (hold_val <= lvl + 10) begin
				hl = needle;
			end else begin
				hl = scale_q16(hold_val);
				if (needle > hl) hl = needle;
			end
		end

		su = 0;
		over = 0;
		if (dv > S9_MDBM) begin
			su = SU_MAX;
			over = (dv - S9_MDBM + 500) / 1000;
			if (over > OVER_MAX) over = OVER_MAX;
		end else if (dv > S0_MDBM) begin
			su = (dv - S0_MDBM + MDB_PER_S_UNIT / 2) / MDB_PER_S_UNIT;
			if (su > SU_MAX) su = SU_MAX;
		end

		r.needle = FRAC_W'(needle);
		r.target = FRAC_W'(tgt);
		r.peak = LVL_W'(pk);
		r.hold = LVL_W'(hold_val);
		r.hold_line = FRAC_W'(hl);
		r.s_units = 4'(su);
		r.over_s9 = 8'(over);
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d readings still due", CYCLE_LIMIT,
			readings_due.size());
		$display("simulation failed");
		$finish;
	end

	// receiver: stall pattern is redrawn at random; rx_hold_left forces a hold-off
	initial begin
		m_tready = 1'b0;
		rx_hold_left = 0;
		rx_mode = 0;
		rx_mode_left = 0;
		rx_phase = 0;
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				m_tready <= 1'b0;
				rx_hold_left--;
			end else begin
				if (rx_mode_left == 0) begin
					rx_mode = $urandom_range(0, 3);
					rx_mode_left = $urandom_range(16, 200);
				end else begin
					rx_mode_left--;
				end
				rx_phase++;
				if (rx_fast) begin
					m_tready <= 1'b1;
				end else begin
					case (rx_mode)
						0: m_tready <= 1'b1;
						1: m_tready <= 1'($urandom_range(0, 1));
						2: m_tready <= ($urandom_range(0, 3) == 0);
						default: m_tready <= ((rx_phase % 8) < 5);
					endcase
				end
			end
		end
	end

	task automatic report_field(string fld, logic signed [31:0] e, logic signed [31:0] a);
		errors++;
		if (errors <= MAX_REPORTS)
			$error("%s mismatch on reading %0d: expected %0d, got %0d", fld, n_results, e, a);
		else if (errors == MAX_REPORTS + 1)
			$display("further mismatches are counted but not shown");
	endtask

	always @(posedge clk) begin
		reading_t got;
		reading_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[$bits(reading_t)-1:0];
			if (readings_due.size() == 0) begin
				errors++;
				$error("reading %0d arrived with no item pending", n_results);
			end else begin
				want = readings_due.pop_front();
				if (got.needle !== want.needle)
					report_field("needle_frac", want.needle, got.needle);
				if (got.target !== want.target)
					report_field("target_frac", want.target, got.target);
				if (got.peak !== want.peak)
					report_field("peak_mdbm", want.peak, got.peak);
				if (got.hold !== want.hold)
					report_field("hold_mdbm", want.hold, got.hold);
				if (got.hold_line !== want.hold_line)
					report_field("hold_line_frac", want.hold_line, got.hold_line);
				if (got.s_units !== want.s_units)
					report_field("s_units", want.s_units, got.s_units);
				if (got.over_s9 !== want.over_s9)
					report_field("over_s9_db", want.over_s9, got.over_s9);
			end
			n_results++;
		end
	end

	task automatic pace_sender();
		int gap;
		if (!tx_gaps) return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
		s_tvalid <= 1'b0;
		repeat (gap) @(negedge clk);
		burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
	endtask

	// called at a falling edge; returns at a falling edge
	task automatic send_item(logic [1:0] cmd, logic [LVL_W-1:0] lvl_raw);
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {{(24 - LVL_W){1'b0}}, lvl_raw};
		do @(posedge clk); while (!s_tready);
		readings_due.push_back(meter_predict(cmd, lvl_raw));
		case (cmd)
			CMD_SAMPLE: n_samples++;
			CMD_TICK: n_ticks++;
			CMD_HOLD_RST: n_hold_rst++;
			default: n_unused++;
		endcase
		@(negedge clk);
		pace_sender();
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (readings_due.size() != 0) @(negedge clk);
	endtask

	task automatic reg_write(cfg_reg_t idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		meter_apply_config(idx, val);
		n_reg_writes++;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(int peak_mode, int hold_en, int hold_time, int decay,
		int attack, int release_a, int snap);
		drain();
		reg_write(REG_PEAK_MODE, 32'(peak_mode));
		reg_write(REG_HOLD_EN, 32'(hold_en));
		reg_write(REG_HOLD_TIME, 32'(hold_time));
		reg_write(REG_DECAY_SEL, 32'(decay));
		reg_write(REG_ATTACK, 32'(attack));
		reg_write(REG_RELEASE, 32'(release_a));
		reg_write(REG_SNAP, 32'(snap));
	endtask

	function automatic logic [LVL_W-1:0] rand_level();
		case ($urandom_range(0, 9))
			0: return LVL_W'($urandom());
			1: return LVL_W'(int'($urandom_range(0, LEVEL_MAX - LEVEL_MIN)) + LEVEL_MIN);
			default: return LVL_W'(int'($urandom_range(0, TOP_MDBM - S0_MDBM + 10000))
				+ S0_MDBM - 5000);
		endcase
	endfunction

	task automatic test_reset_state();
		send_item(CMD_NOP, '0);
		send_item(CMD_TICK, '1);
		send_item(CMD_HOLD_RST, '0);
	endtask

	task automatic test_scale_points();
		send_item(CMD_SAMPLE, LVL_W'(LEVEL_MIN));
		send_item(CMD_SAMPLE, 19'h40000);
		send_item(CMD_SAMPLE, 19'h3FFFF);
		send_item(CMD_SAMPLE, LVL_W'(LEVEL_MAX));
		send_item(CMD_SAMPLE, LVL_W'(S0_MDBM));
		send_item(CMD_SAMPLE, LVL_W'(S0_MDBM + 1));
		send_item(CMD_SAMPLE, LVL_W'(S0_MDBM + MDB_PER_S_UNIT / 2 - 1));
		send_item(CMD_SAMPLE, LVL_W'(S0_MDBM + MDB_PER_S_UNIT / 2));
		send_item(CMD_SAMPLE, LVL_W'(S9_MDBM));
		send_item(CMD_SAMPLE, LVL_W'(S9_MDBM + 499));
		send_item(CMD_SAMPLE, LVL_W'(S9_MDBM + 500));
		send_item(CMD_SAMPLE, LVL_W'(TOP_MDBM));
		send_item(CMD_SAMPLE, LVL_W'(TOP_MDBM + 1));
	endtask

	task automatic test_hold_line();
		set_config(0, 1, 100, DECAY_FAST, 65535, 65535, 0);
		send_item(CMD_SAMPLE, LVL_W'(S0_MDBM + 500));
		send_item(CMD_SAMPLE, LVL_W'(-60000));
		send_item(CMD_SAMPLE, LVL_W'(-100000));
		send_item(CMD_SAMPLE, LVL_W'(-99995));
		send_item(CMD_TICK, '0);
		send_item(CMD_NOP, '1);
		send_item(CMD_HOLD_RST, '0);
		send_item(CMD_SAMPLE, LVL_W'(-99990));
		drain();
		reg_write(REG_PEAK_MODE, 32'd1);
		send_item(CMD_SAMPLE, LVL_W'(-20000));
		send_item(CMD_TICK, '0);
	endtask

	task automatic random_traffic(int budget);
		int sent;
		int r;
		int n;
		sent = 0;
		while (sent < budget) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				send_item(CMD_SAMPLE, rand_level());
				n = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 60);
				repeat (n) send_item(CMD_TICK, LVL_W'($urandom()));
				sent += n + 1;
			end else if (r < 60) begin
				send_item(CMD_SAMPLE, rand_level());
				sent++;
			end else if (r < 85) begin
				n = $urandom_range(1, 20);
				repeat (n) send_item(CMD_TICK, LVL_W'($urandom()));
				sent += n;
			end else if (r < 93) begin
				send_item(CMD_HOLD_RST, LVL_W'($urandom()));
				sent++;
			end else if (r < 97) begin
				send_item(CMD_NOP, LVL_W'($urandom()));
			end else begin
				send_item(CMD_SAMPLE, LVL_W'($urandom()));
				sent++;
			end
		end
	endtask

	task automatic test_random_phases();
		int p;
		for (p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: set_config(0, 1, 100, DECAY_FAST, 65535, 65535, 0);
				1: set_config(1, 1, 2000, DECAY_SLOW, 0, 0, 4096);
				2: set_config(1, 1, 0, 3, 16384, 4096, 8191);
				3: set_config(0, 0, 2047, DECAY_MED, 1, 1, 1);
				default: set_config($urandom_range(0, 1), ($urandom_range(0, 3) != 0),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(100, 400),
					$urandom_range(0, 3), $urandom_range(0, 65535), $urandom_range(0, 65535),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 300));
			endcase
			random_traffic(RANDOM_ITEMS / RANDOM_PHASES);
		end
	endtask

	task automatic test_backpressure();
		int i;
		drain();
		tx_gaps = 1'b0;
		rx_hold_left = 300;
		for (i = 0; i < 60; i++)
			send_item(($urandom_range(0, 2) == 0) ? CMD_SAMPLE : CMD_TICK, rand_level());
		drain();
		tx_gaps = 1'b1;
	endtask

	// back-to-back tick run: peak steps down and the hold line decays past its hold time
	task automatic test_long_tick_run();
		set_config(1, 1, 100, DECAY_SLOW, 30000, 3000, 66);
		tx_gaps = 1'b0;
		rx_fast = 1'b1;
		send_item(CMD_SAMPLE, LVL_W'(LEVEL_MAX));
		send_item(CMD_SAMPLE, LVL_W'(LEVEL_MIN));
		repeat (LONG_TICKS) send_item(CMD_TICK, '0);
		send_item(CMD_SAMPLE, LVL_W'(LEVEL_MIN));
		send_item(CMD_TICK, '0);
		drain();
		rx_fast = 1'b0;
		tx_gaps = 1'b1;
	endtask

	initial begin
		meter_reset();
		errors = 0;
		n_results = 0;
		n_samples = 0;
		n_ticks = 0;
		n_hold_rst = 0;
		n_unused = 0;
		n_reg_writes = 0;
		tx_gaps = 1'b1;
		burst_left = 0;
		rx_fast = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_SAMPLE;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		test_scale_points();
		test_hold_line();
		test_random_phases();
		test_backpressure();
		test_long_tick_run();

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (readings_due.size() != 0) begin
			errors++;
			$error("%0d readings never arrived", readings_due.size());
		end
		$display("covered %0d samples, %0d ticks, %0d hold-line resets, %0d unused commands",
			n_samples, n_ticks, n_hold_rst, n_unused);
		$display("%0d register writes, %0d readings checked, %0d field errors",
			n_reg_writes, n_results, errors);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
